[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and command codes for the timer slot table.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int REQ_W   = 4;
    localparam int INDEX_W = 6;
    localparam int STAMP_W = 16;

    typedef logic [REQ_W-1:0]   req_code_t;
    typedef logic [INDEX_W-1:0] slot_index_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    localparam req_code_t REQ_TICK      = 4'd0;
    localparam req_code_t REQ_START     = 4'd1;
    localparam req_code_t REQ_RESTART   = 4'd2;
    localparam req_code_t REQ_GET_TICK  = 4'd3;
    localparam req_code_t REQ_CHECK     = 4'd4;
    localparam req_code_t REQ_CHK_RST   = 4'd5;
    localparam req_code_t REQ_CHK_STOP  = 4'd6;
    localparam req_code_t REQ_STOP      = 4'd7;
    localparam req_code_t REQ_GET_START = 4'd8;

    localparam stamp_t STAMP_IDLE    = 16'h0000;
    localparam stamp_t RESULT_BADIDX = 16'hFFFF;
    localparam stamp_t RESULT_ZERO   = 16'h0000;
    localparam stamp_t RESULT_ONE    = 16'h0001;

    // command unit decision for one slot
    typedef struct packed {
        logic   wr_en;
        stamp_t wr_data;
        logic   has_result;
        stamp_t result;
    } cmd_act_t;

endpackage

[rtl/stt_if.sv]
// ----------------------------------------------------------------------------
// stt_cmd_if / stt_rsp_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface stt_cmd_if import stt_pkg::*; ();
    logic        valid;
    logic        ready;
    req_code_t   req_type;
    slot_index_t slot_index;
    stamp_t      timeout;

    modport source (output valid, output req_type, output slot_index, output timeout,
                    input ready);
    modport sink (input valid, input req_type, input slot_index, input timeout,
                  output ready);
endinterface

interface stt_rsp_if import stt_pkg::*; ();
    logic   valid;
    logic   ready;
    stamp_t result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

[rtl/stt_slot_mem.sv]
// ----------------------------------------------------------------------------
// stt_slot_mem
// Start-stamp memory: one read, one write port, registered read data,
// write-first bypass and per-entry valid bits (invalid reads as idle).
// ----------------------------------------------------------------------------
module stt_slot_mem
    import stt_pkg::*;
#(
    parameter int SLOTS = 32,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  stamp_t        wr_data,
    output stamp_t        rd_data
);

    stamp_t             mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg;
    stamp_t             rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // same-cycle write to the entry being read wins
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= STAMP_IDLE;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/stt_cmd_unit.sv]
// ----------------------------------------------------------------------------
// stt_cmd_unit
// Decodes one command against the slot's stamp and the current tick:
// expiry test, write-back value and result.
// ----------------------------------------------------------------------------
module stt_cmd_unit
    import stt_pkg::*;
(
    input  req_code_t req_type,
    input  stamp_t    start,
    input  stamp_t    now,
    input  stamp_t    timeout,
    output cmd_act_t  act
);

    stamp_t elapsed;
    logic   running;
    logic   expired;

    // after a wrap the elapsed time is one short of the modular difference
    assign elapsed = (now < start) ? (now - start - 16'd1) : (now - start);
    assign running = (start != STAMP_IDLE);
    assign expired = running && (elapsed > timeout);

    always_comb
    begin
        act.wr_en      = 1'b0;
        act.wr_data    = STAMP_IDLE;
        act.has_result = 1'b1;
        act.result     = RESULT_ZERO;
        unique case (req_type)
            REQ_TICK:
            begin
                act.has_result = 1'b0;
            end
            REQ_START:
            begin
                if (!running)
                begin
                    act.wr_en   = 1'b1;
                    act.wr_data = now;
                end
                else
                begin
                    act.result = start;
                end
            end
            REQ_RESTART:
            begin
                act.wr_en   = 1'b1;
                act.wr_data = now;
                act.result  = now;
            end
            REQ_GET_TICK:
            begin
                act.result = now;
            end
            REQ_CHECK:
            begin
                act.result = expired ? RESULT_ONE : RESULT_ZERO;
            end
            REQ_CHK_RST:
            begin
                act.wr_en   = expired;
                act.wr_data = now;
                act.result  = expired ? RESULT_ONE : RESULT_ZERO;
            end
            REQ_CHK_STOP:
            begin
                act.wr_en  = expired;
                act.result = expired ? RESULT_ONE : RESULT_ZERO;
            end
            REQ_STOP:
            begin
                act.wr_en  = running;
                act.result = expired ? RESULT_ONE : RESULT_ZERO;
            end
            REQ_GET_START:
            begin
                act.result = start;
            end
            default:
            begin
                // unused codes clear the slot
                act.wr_en  = 1'b1;
                act.result = RESULT_ONE;
            end
        endcase
    end

endmodule

[rtl/software_timer_slot_table_unit.sv]
// ----------------------------------------------------------------------------
// software_timer_slot_table_unit
// Timer slot table with a 16-bit tick counter that advances on tick commands.
// ----------------------------------------------------------------------------
// Takes one command per clock cycle. A command is accepted, its slot is read
// from the start-stamp memory in the same edge, and when the command stage
// advances the stamp is tested, written back and the result is loaded into
// the output register. The rate is set by the single read-modify-write per
// command on the slot memory; a command that hits the slot written by its
// predecessor gets the new stamp through a write-first bypass. Tick items
// advance the counter and give no result.
// Acceptance stalls only while a finished result is held and not taken.
// All slots read as idle right after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module software_timer_slot_table_unit
    import stt_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input logic     clk,
    input logic     rst_n,
    stt_cmd_if.sink   cmd,
    stt_rsp_if.source rsp
);

    localparam int          AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam slot_index_t SLOT_LIM = INDEX_W'(SLOTS);

    logic          s1_valid_reg;
    logic          s1_valid_next;
    req_code_t     s1_req_reg;
    logic          s1_bad_reg;
    logic [AW-1:0] s1_addr_reg;
    stamp_t        s1_tmo_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    stamp_t        out_result_reg;

    stamp_t        tick_reg;
    stamp_t        tick_next;

    logic          accept;
    logic          in_range;
    logic          s1_is_tick;
    logic          s1_fire;
    logic          out_free;
    logic          mem_we;
    stamp_t        slot_stamp;
    cmd_act_t      act;

    assign in_range   = (cmd.slot_index < SLOT_LIM);
    assign s1_is_tick = (s1_req_reg == REQ_TICK);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign s1_fire    = s1_valid_reg && (s1_is_tick || out_free);
    assign cmd.ready  = !s1_valid_reg || s1_fire;
    assign accept     = cmd.valid && cmd.ready;
    assign mem_we     = s1_fire && !s1_bad_reg && act.wr_en;

    stt_slot_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range && (cmd.req_type != REQ_TICK)),
        .rd_addr (cmd.slot_index[AW-1:0]),
        .wr_en   (mem_we),
        .wr_addr (s1_addr_reg),
        .wr_data (act.wr_data),
        .rd_data (slot_stamp)
    );

    stt_cmd_unit u_cmd (
        .req_type (s1_req_reg),
        .start    (slot_stamp),
        .now      (tick_reg),
        .timeout  (s1_tmo_reg),
        .act      (act)
    );

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        tick_next      = (s1_fire && s1_is_tick) ? (tick_reg + 16'd1) : tick_reg;
        out_valid_next = (s1_fire && act.has_result) ? 1'b1
                       : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            tick_reg      <= tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg  <= cmd.req_type;
            s1_bad_reg  <= !in_range;
            s1_addr_reg <= cmd.slot_index[AW-1:0];
            s1_tmo_reg  <= cmd.timeout;
        end
        if (s1_fire && act.has_result)
        begin
            out_result_reg <= s1_bad_reg ? RESULT_BADIDX : act.result;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.result = out_result_reg;

    // a held command blocks acceptance
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |-> !cmd.ready)
        else $error("command accepted while stage is stalled");

    // bad index never touches the table
    a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_bad_reg) |-> !mem_we)
        else $error("write to table on out-of-range slot");

    // a tick advances the counter by exactly one and loads no result
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_is_tick) |=> (tick_reg == $past(tick_reg) + 16'd1))
        else $error("tick counter did not advance");

    // a result only appears after a non-tick command completes
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && !s1_is_tick))
        else $error("result without a completed command");

endmodule
